/* hdl/xerd_pkg.sv */
// Shared types and constants of the XML entity reference decoder.
package xerd_pkg;

    // Most result words that one input byte can cause.
    localparam int MAX_WORDS = 4;
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int IDX_W     = $clog2(MAX_WORDS);

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_NAMED = 3'd1,
        ERR_SEMI  = 3'd2,
        ERR_RANGE = 3'd3,
        ERR_EOS   = 3'd4
    } t_err;

    // One result word.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        t_err       err;
    } t_word;

    // All result words of one input byte, oldest in slot 0.
    typedef struct packed {
        t_word [MAX_WORDS-1:0] words;
        logic  [CNT_W-1:0]     cnt;
        logic                  done;
    } t_cmd;

endpackage

/* hdl/xml_entity_reference_decoder.sv */
// Top level of the XML entity reference decoder with UTF-8 output.
// The first result word of a byte passes through the result queue and then the output register.
// Throughput: one input byte per cycle; the output side sends one word per cycle while the
// receiver is ready, so a byte of n words (up to four for a character reference) holds it longer.
// A result queue of QUEUE_DEPTH groups absorbs these bursts; input stalls only when it fills.
// Reset is synchronous and active low; it empties the queue and returns to string start.
module xml_entity_reference_decoder import xerd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input byte stream.
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // end_of_string
    // Decoded result stream.
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [3:0] o_m_tuser,   // [0] byte_valid, [3:1] error_code
    output logic       o_m_tlast    // string_done
);

    localparam int CMD_W = $bits(t_cmd);

    // The front end turns each accepted byte into a group of up to four result words.
    // The group is written straight into the queue, so the front end never waits on
    // the output side unless the queue is full.
    t_cmd  front_cmd;
    t_cmd  head_cmd;
    logic  front_push;
    logic  q_full;
    logic  q_empty;
    logic  back_pop;
    t_word out_word;

    xerd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_eos   (i_s_tlast),
        .o_push  (front_push),
        .o_cmd   (front_cmd),
        .i_full  (q_full)
    );

    xerd_fifo #(
        .W     (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    // The back end walks through the words of the head group, one per cycle while the output
    // is not stalled, into an output register, and pops the group as its last word is loaded.
    xerd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_empty  (q_empty),
        .o_pop    (back_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_word   (out_word),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = out_word.data;
    assign o_m_tuser = {out_word.err, out_word.valid};

endmodule

/* hdl/xerd_fifo.sv */
// Small register queue between the decoder front end and the output back end.
module xerd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/xerd_front.sv */
// Front end: accepts input bytes, tracks entity parsing and builds result words.
module xerd_front import xerd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_O    = 8'h6F;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_Q    = 8'h71;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_X    = 8'h78;

    localparam logic [20:0] CODE_LIMIT = 21'h110000;
    localparam logic [20:0] CODE_SAT   = 21'h1FFFFF;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_AMP,
        PH_NAMED,
        PH_HASH,
        PH_DEC,
        PH_HEX
    } t_phase;

    typedef enum logic [2:0] {
        ENT_AMP  = 3'd0,
        ENT_APOS = 3'd1,
        ENT_GT   = 3'd2,
        ENT_LT   = 3'd3,
        ENT_QUOT = 3'd4
    } t_ent;

    // Expected character at a position of a named entity; NUL past its end.
    function automatic logic [7:0] ent_text(t_ent k, logic [2:0] p);
        logic [7:0] c;
        c = CH_NUL;
        unique case (k)
            ENT_AMP: begin
                unique case (p)
                    3'd0: c = CH_A;
                    3'd1: c = CH_M;
                    3'd2: c = CH_P;
                    3'd3: c = CH_SEMI;
                    default: c = CH_NUL;
                endcase
            end
            ENT_APOS: begin
                unique case (p)
                    3'd0: c = CH_A;
                    3'd1: c = CH_P;
                    3'd2: c = CH_O;
                    3'd3: c = CH_S;
                    3'd4: c = CH_SEMI;
                    default: c = CH_NUL;
                endcase
            end
            ENT_GT, ENT_LT: begin
                unique case (p)
                    3'd0: c = (k == ENT_GT) ? CH_G : CH_L;
                    3'd1: c = CH_T;
                    3'd2: c = CH_SEMI;
                    default: c = CH_NUL;
                endcase
            end
            ENT_QUOT: begin
                unique case (p)
                    3'd0: c = CH_Q;
                    3'd1: c = CH_U;
                    3'd2: c = CH_O;
                    3'd3: c = CH_T;
                    3'd4: c = CH_SEMI;
                    default: c = CH_NUL;
                endcase
            end
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ent_char(t_ent k);
        logic [7:0] c;
        unique case (k)
            ENT_AMP:  c = CH_AMP;
            ENT_APOS: c = CH_SQ;
            ENT_GT:   c = CH_GT;
            ENT_LT:   c = CH_LT;
            ENT_QUOT: c = CH_DQ;
            default:  c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic t_cmd put_word(t_cmd c, logic [7:0] b, logic v, t_err e);
        t_cmd r;
        r = c;
        if (c.cnt < CNT_W'(MAX_WORDS)) begin
            r.words[c.cnt[IDX_W-1:0]] = '{data: b, valid: v, err: e};
            r.cnt = c.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic t_cmd put_utf8(t_cmd c, logic [20:0] cp);
        t_cmd r;
        r = c;
        if (cp < 21'h80) begin
            r = put_word(r, cp[7:0], 1'b1, ERR_NONE);
        end else if (cp < 21'h800) begin
            r = put_word(r, {3'b110, cp[10:6]}, 1'b1, ERR_NONE);
            r = put_word(r, {2'b10, cp[5:0]}, 1'b1, ERR_NONE);
        end else if (cp < 21'h10000) begin
            r = put_word(r, {4'b1110, cp[15:12]}, 1'b1, ERR_NONE);
            r = put_word(r, {2'b10, cp[11:6]}, 1'b1, ERR_NONE);
            r = put_word(r, {2'b10, cp[5:0]}, 1'b1, ERR_NONE);
        end else begin
            r = put_word(r, {5'b11110, cp[20:18]}, 1'b1, ERR_NONE);
            r = put_word(r, {2'b10, cp[17:12]}, 1'b1, ERR_NONE);
            r = put_word(r, {2'b10, cp[11:6]}, 1'b1, ERR_NONE);
            r = put_word(r, {2'b10, cp[5:0]}, 1'b1, ERR_NONE);
        end
        return r;
    endfunction

    // Accumulator times ten or sixteen plus one digit, with headroom.
    function automatic logic [25:0] acc_next(logic [20:0] acc, logic hex, logic [3:0] dig);
        logic [25:0] a;
        a = {5'b0, acc};
        return hex ? ((a << 4) + {22'b0, dig}) : ((a << 3) + (a << 1) + {22'b0, dig});
    endfunction

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_mpos,   n_mpos;
    t_ent        r_kind,   n_kind;
    logic [20:0] r_acc,    n_acc;
    logic        r_ovf,    n_ovf;
    logic        r_first,  n_first;
    logic        r_quoted, n_quoted;
    logic        r_skip,   n_skip;

    logic accept;
    t_cmd cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (cmd.cnt != '0);
    assign o_cmd   = cmd;

    always_comb begin
        t_phase      ph;
        t_ent        k;
        logic        handled;
        logic        serr;
        logic        is_dec;
        logic        is_hexl;
        logic        is_hexu;
        logic        do_acc;
        logic        do_fin;
        logic [7:0]  dig8;
        logic [25:0] v;

        n_phase  = r_phase;
        n_mpos   = r_mpos;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_first  = r_first;
        n_quoted = r_quoted;
        n_skip   = r_skip;
        cmd      = '0;
        ph       = r_phase;
        k        = r_kind;
        handled  = 1'b0;
        serr     = 1'b0;
        do_acc   = 1'b0;
        do_fin   = 1'b0;
        is_dec   = (i_byte >= CH_0) && (i_byte <= CH_9);
        is_hexl  = (i_byte >= CH_A) && (i_byte <= CH_F);
        is_hexu  = (i_byte >= CH_UA) && (i_byte <= CH_UF);
        if (is_dec) begin
            dig8 = i_byte - CH_0;
        end else if (is_hexl) begin
            dig8 = i_byte - CH_A + 8'd10;
        end else begin
            dig8 = i_byte - CH_UA + 8'd10;
        end
        v = acc_next(r_acc, (r_phase == PH_HEX), dig8[3:0]);

        if (r_skip) begin
            // Rest of the string after an error is dropped.
        end else if (r_first && (i_byte == CH_SQ || i_byte == CH_DQ)) begin
            n_first  = 1'b0;
            n_quoted = 1'b1;
        end else begin
            n_first = 1'b0;
            if (!(r_quoted && i_eos)) begin
                if (ph == PH_AMP) begin
                    ph      = PH_IDLE;
                    n_mpos  = 3'd1;
                    n_acc   = '0;
                    n_ovf   = 1'b0;
                    handled = 1'b1;
                    unique case (i_byte)
                        CH_A: begin
                            n_kind = ENT_AMP;
                            ph     = PH_NAMED;
                        end
                        CH_G: begin
                            n_kind = ENT_GT;
                            ph     = PH_NAMED;
                        end
                        CH_L: begin
                            n_kind = ENT_LT;
                            ph     = PH_NAMED;
                        end
                        CH_Q: begin
                            n_kind = ENT_QUOT;
                            ph     = PH_NAMED;
                        end
                        CH_HASH: begin
                            ph = PH_HASH;
                        end
                        default: begin
                            // Not an entity: the ampersand is literal and the
                            // byte goes on as plain text.
                            cmd     = put_word(cmd, CH_AMP, 1'b1, ERR_NONE);
                            handled = 1'b0;
                        end
                    endcase
                end
                if (!handled) begin
                    if (ph == PH_NAMED) begin
                        k = n_kind;
                        if (k == ENT_AMP && n_mpos == 3'd1 && i_byte == CH_P) begin
                            k      = ENT_APOS;
                            n_kind = ENT_APOS;
                        end
                        if (n_mpos > 3'd5 || ent_text(k, n_mpos) != i_byte
                                || i_byte == CH_NUL) begin
                            cmd  = put_word(cmd, 8'h00, 1'b0, ERR_NAMED);
                            serr = 1'b1;
                            ph   = PH_IDLE;
                        end else if (i_byte == CH_SEMI) begin
                            ph  = PH_IDLE;
                            cmd = put_word(cmd, ent_char(k), 1'b1, ERR_NONE);
                        end else begin
                            n_mpos = n_mpos + 3'd1;
                        end
                    end else begin
                        if (ph == PH_HASH) begin
                            if (i_byte == CH_X) begin
                                ph      = PH_HEX;
                                handled = 1'b1;
                            end else begin
                                ph = PH_DEC;
                            end
                        end
                        if (!handled) begin
                            if (ph == PH_DEC) begin
                                do_acc = is_dec;
                                do_fin = !is_dec;
                            end else if (ph == PH_HEX) begin
                                do_acc = is_dec || is_hexl || is_hexu;
                                do_fin = !(is_dec || is_hexl || is_hexu);
                            end else begin
                                ph = PH_IDLE;
                                if (i_byte == CH_AMP) begin
                                    ph = PH_AMP;
                                end else begin
                                    cmd = put_word(cmd, i_byte, 1'b1, ERR_NONE);
                                end
                            end
                        end
                    end
                end
                if (do_acc && !n_ovf) begin
                    // Overflow saturates and stays set until the terminator.
                    if (v >= {5'b0, CODE_LIMIT}) begin
                        n_ovf = 1'b1;
                        n_acc = CODE_SAT;
                    end else begin
                        n_acc = v[20:0];
                    end
                end
                if (do_fin) begin
                    if (i_byte != CH_SEMI) begin
                        cmd  = put_word(cmd, 8'h00, 1'b0, ERR_SEMI);
                        serr = 1'b1;
                        ph   = PH_IDLE;
                    end else if (n_ovf || n_acc >= CODE_LIMIT) begin
                        cmd  = put_word(cmd, 8'h00, 1'b0, ERR_RANGE);
                        serr = 1'b1;
                        ph   = PH_IDLE;
                    end else begin
                        ph  = PH_IDLE;
                        cmd = put_utf8(cmd, n_acc);
                    end
                end
            end
            if (serr) begin
                n_skip = 1'b1;
            end else if (i_eos) begin
                if (ph == PH_AMP) begin
                    cmd = put_word(cmd, CH_AMP, 1'b1, ERR_NONE);
                end else if (ph != PH_IDLE) begin
                    cmd = put_word(cmd, 8'h00, 1'b0, ERR_EOS);
                end
            end
            n_phase = ph;
        end

        if (i_eos) begin
            if (cmd.cnt == '0) begin
                cmd = put_word(cmd, 8'h00, 1'b0, ERR_NONE);
            end
            cmd.done = 1'b1;
            n_phase  = PH_IDLE;
            n_mpos   = '0;
            n_kind   = ENT_AMP;
            n_acc    = '0;
            n_ovf    = 1'b0;
            n_first  = 1'b1;
            n_quoted = 1'b0;
            n_skip   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_mpos   <= '0;
            r_kind   <= ENT_AMP;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_first  <= 1'b1;
            r_quoted <= 1'b0;
            r_skip   <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_mpos   <= n_mpos;
            r_kind   <= n_kind;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_first  <= n_first;
            r_quoted <= n_quoted;
            r_skip   <= n_skip;
        end
    end

endmodule

/* hdl/xerd_back.sv */
// Back end: unpacks queued result groups into single words on the output register.
module xerd_back import xerd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  logic  i_empty,
    output logic  o_pop,
    output logic  o_tvalid,
    input  logic  i_tready,
    output t_word o_word,
    output logic  o_last
);

    logic [IDX_W-1:0] r_idx;
    logic             r_ovalid;
    t_word            r_word;
    logic             r_last;
    logic             load;
    logic             last_of_cmd;

    assign load        = !i_empty && (!r_ovalid || i_tready);
    assign last_of_cmd = (CNT_W'(r_idx) == i_cmd.cnt - 1'b1);
    assign o_pop       = load && last_of_cmd;
    assign o_tvalid    = r_ovalid;
    assign o_word      = r_word;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
            r_word   <= i_cmd.words[r_idx];
            r_last   <= i_cmd.done && last_of_cmd;
            r_idx    <= last_of_cmd ? '0 : r_idx + 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

endmodule

/* hdl/xerd_checker.sv */
// Port-level checks of the XML entity reference decoder, bound to its top level.
module xerd_checker import xerd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [3:0] o_m_tuser,
    input logic       o_m_tlast
);

    // A word that waits on the output side holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // Reset drops any pending output word.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Marker and error words carry a zero byte.
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 8'h00)
        else $error("marker word with nonzero byte");

    // An error word never carries data.
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[3:1] != ERR_NONE |-> !o_m_tuser[0])
        else $error("error word marked as data");

endmodule

bind xml_entity_reference_decoder xerd_checker u_xerd_checker (.*);
